// ===== design/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the best-fit block allocator
// Heap geometry, field layouts of request and result, block tag format.
// ----------------------------------------------------------------------------
`default_nettype none

package fbba_pkg;

  // heap geometry
  localparam int PAGE_BYTES     = 4096;
  localparam int MAX_PAGES      = 4;
  localparam int SPLINTER_LIMIT = 32;
  localparam int GRAN_BYTES     = 16;
  localparam int MAX_REQUEST    = 16368;

  localparam int PAGE_G = PAGE_BYTES / GRAN_BYTES;
  localparam int HEAP_G = PAGE_G * MAX_PAGES;
  localparam int AW     = $clog2(HEAP_G);
  localparam int CW     = AW + 1;
  localparam int PW     = $clog2(MAX_PAGES + 1);
  localparam int SPL_G  = (SPLINTER_LIMIT + GRAN_BYTES - 1) / GRAN_BYTES;
  localparam int SRW    = $clog2(SPL_G + 1);

  // operation and status codes
  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [13:0] request_size;
    logic [15:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] payload_address;
    logic [14:0] block_bytes;
    logic [3:0]  padding_bytes;
    logic [4:0]  splinter_bytes;
  } out_item_t;

  // boundary tag kept in header and footer stores
  typedef struct packed {
    logic [CW-1:0] size;
    logic          spl;
    logic          alloc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one port request to a tag store
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    entry_t        wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== design/fbba_ram.sv =====
// ----------------------------------------------------------------------------
// fbba_ram: generic single-port RAM
// One read or write per cycle at one address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/fbba_out_reg.sv =====
// ----------------------------------------------------------------------------
// fbba_out_reg: result output register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  fbba_pkg::out_item_t din,
  input  logic               stall,
  output logic               valid,
  output fbba_pkg::out_item_t dout,
  output logic               ready
);
  import fbba_pkg::*;

  // free when empty or when the held result leaves this cycle
  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ===== design/best_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_block_allocator: best-fit heap allocator with coalescing
// Sequencer walks block headers; header and
// footer tag stores in RAM, one result per request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    in_data  (operation, size, address)
//  out       out  out_valid / out_stall  out_data (status, address, sizes)
//
//  One request at a time: each block walked costs a tag RAM read, and
//  adding a page, finishing an alloc and the free checks add their own states.
//  Cycles follow the number of blocks in the heap, set by the header walk.
//  Synchronous reset clears page count; tag RAMs need no clearing.
//  in_stall is high while a request is in progress; a finished result waits
//  in the output register, and the next request is taken once it is loaded.
`default_nettype none

module best_fit_block_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbba_pkg::out_item_t out_data
);
  import fbba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_PAGE, S_PAGE_EV, S_PAGE_WR, S_WALK_RD, S_WALK_EV, S_FIT,
    S_ALLOC_WR, S_FW_RD, S_FW_EV, S_FH_EV, S_FF_EV, S_FL_EV, S_FR_RD,
    S_FR_EV, S_FREE_WR, S_RESP
  } state_t;

  state_t        state;
  logic [PW-1:0] pages;
  logic [CW-1:0] endg;
  logic [CW-1:0] cur, tgt, need, best, bpos, pos, s, start, total, bs, hsize;
  logic [SRW-1:0] spl_r;
  logic [3:0]    pad;
  logic          hspl;
  out_item_t     res;

  mem_req_t hdr_req, ftr_req;
  entry_t   hdr_rd, ftr_rd;

  logic          ob_ready, res_load;

  // tag stores
  fbba_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_G)) u_hdr (
    .clk(clk), .we(hdr_req.we), .addr(hdr_req.addr),
    .wdata(hdr_req.wdata), .rdata(hdr_rd)
  );

  fbba_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_G)) u_ftr (
    .clk(clk), .we(ftr_req.we), .addr(ftr_req.addr),
    .wdata(ftr_req.wdata), .rdata(ftr_rd)
  );

  // result buffer
  fbba_out_reg u_out (
    .clk(clk), .rst(rst), .load(res_load), .din(res), .stall(out_stall),
    .valid(out_valid), .dout(out_data), .ready(ob_ready)
  );

  assign in_stall = (state != S_IDLE);
  assign res_load = (state == S_RESP) && ob_ready;

  // request decode
  logic [3:0]    in_pad;
  logic [14:0]   in_padded;
  logic [CW-1:0] in_need;
  logic          free_bad;
  logic [11:0]   free_g;

  assign in_pad    = 4'(5'd16 - {1'b0, in_data.request_size[3:0]});
  assign in_padded = {1'b0, in_data.request_size} + {11'd0, in_pad};
  assign in_need   = CW'(in_padded >> 4) + CW'(1);
  assign free_g    = in_data.block_address[15:4];
  assign free_bad  = (pages == '0) || (in_data.block_address[3:0] != 4'd8)
                  || ({1'b0, free_g} >= 13'(endg));

  // tag sizes, a zero size walks as one granule
  logic [CW-1:0] hsz;
  assign hsz = (hdr_rd.size == '0) ? CW'(1) : hdr_rd.size;

  // free tail block in front of a new page
  logic [CW-1:0] page_tail;
  always_comb begin
    page_tail = ftr_rd.size;
    if (page_tail == '0 || page_tail > endg) begin
      page_tail = CW'(1);
    end
  end

  // fit remainder and split decision
  logic [CW-1:0] fit_rem;
  logic          fit_split;
  assign fit_rem   = s - need;
  assign fit_split = (fit_rem >= CW'(SPL_G));

  logic [CW:0] fh_end;
  logic [CW-1:0] fr_pos;
  assign fh_end = {1'b0, tgt} + {1'b0, hsz};
  assign fr_pos = tgt + s;

  // tag RAM port requests
  always_comb begin
    hdr_req = '0;
    ftr_req = '0;
    unique case (state)
      S_WALK_RD: hdr_req.addr = cur[AW-1:0];
      S_FW_RD:   hdr_req.addr = (cur < tgt) ? cur[AW-1:0] : tgt[AW-1:0];
      S_FR_RD:   hdr_req.addr = fr_pos[AW-1:0];
      S_ADD_PAGE: ftr_req.addr = AW'(endg - CW'(1));
      S_FH_EV:   ftr_req.addr = AW'(fh_end - (CW+1)'(1));
      S_FF_EV:   ftr_req.addr = AW'(tgt - CW'(1));
      S_PAGE_WR, S_FREE_WR: begin
        hdr_req.we    = 1'b1;
        hdr_req.addr  = start[AW-1:0];
        hdr_req.wdata = '{size: total, spl: 1'b0, alloc: 1'b0};
        ftr_req.we    = 1'b1;
        ftr_req.addr  = AW'(start + total - CW'(1));
        ftr_req.wdata = '{size: total, spl: 1'b0, alloc: 1'b0};
      end
      S_FIT: begin
        if (fit_split) begin
          hdr_req.we    = 1'b1;
          hdr_req.addr  = AW'(pos + need);
          hdr_req.wdata = '{size: fit_rem, spl: 1'b0, alloc: 1'b0};
          ftr_req.we    = 1'b1;
          ftr_req.addr  = AW'(pos + s - CW'(1));
          ftr_req.wdata = '{size: fit_rem, spl: 1'b0, alloc: 1'b0};
        end
      end
      S_ALLOC_WR: begin
        hdr_req.we    = 1'b1;
        hdr_req.addr  = pos[AW-1:0];
        hdr_req.wdata = '{size: bs, spl: (spl_r != '0), alloc: 1'b1};
        ftr_req.we    = 1'b1;
        ftr_req.addr  = AW'(pos + bs - CW'(1));
        ftr_req.wdata = '{size: bs, spl: (spl_r != '0), alloc: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pages <= '0;
      endg  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur  <= '0;
            best <= '0;
            pad  <= in_pad;
            need <= in_need;
            tgt  <= CW'(free_g);
            if (in_data.operation == OP_ALLOC) begin
              if (in_data.request_size == '0) begin
                res   <= '{status: ST_INVAL, default: '0};
                state <= S_RESP;
              end else if (in_data.request_size > 14'(MAX_REQUEST)) begin
                res   <= '{status: ST_OOM, default: '0};
                state <= S_RESP;
              end else if (pages == '0) begin
                state <= S_ADD_PAGE;
              end else begin
                state <= S_WALK_RD;
              end
            end else begin
              if (free_bad) begin
                res   <= '{status: ST_INVAL, default: '0};
                state <= S_RESP;
              end else begin
                state <= S_FW_RD;
              end
            end
          end
        end
        // grow the heap by one page
        S_ADD_PAGE: begin
          if (pages >= PW'(MAX_PAGES)) begin
            res   <= '{status: ST_OOM, default: '0};
            state <= S_RESP;
          end else if (endg == '0) begin
            start <= '0;
            total <= CW'(PAGE_G);
            state <= S_PAGE_WR;
          end else begin
            state <= S_PAGE_EV;
          end
        end
        S_PAGE_EV: begin
          if (!ftr_rd.alloc) begin
            start <= endg - page_tail;
            total <= page_tail + CW'(PAGE_G);
          end else begin
            start <= endg;
            total <= CW'(PAGE_G);
          end
          state <= S_PAGE_WR;
        end
        S_PAGE_WR: begin
          pages <= pages + PW'(1);
          endg  <= endg + CW'(PAGE_G);
          cur   <= '0;
          best  <= '0;
          state <= S_WALK_RD;
        end
        // best-fit walk over the blocks, stopping early on an exact fit
        S_WALK_RD: begin
          if (cur >= endg) begin
            if (best != '0) begin
              pos   <= bpos;
              s     <= best;
              state <= S_FIT;
            end else begin
              state <= S_ADD_PAGE;
            end
          end else begin
            state <= S_WALK_EV;
          end
        end
        S_WALK_EV: begin
          if (!hdr_rd.alloc && hsz == need) begin
            pos   <= cur;
            s     <= hsz;
            state <= S_FIT;
          end else begin
            if (!hdr_rd.alloc && hsz > need && (best == '0 || hsz < best)) begin
              best <= hsz;
              bpos <= cur;
            end
            cur   <= cur + hsz;
            state <= S_WALK_RD;
          end
        end
        S_FIT: begin
          if (fit_split) begin
            bs    <= need;
            spl_r <= '0;
          end else begin
            bs    <= s;
            spl_r <= fit_rem[SRW-1:0];
          end
          state <= S_ALLOC_WR;
        end
        S_ALLOC_WR: begin
          res.status          <= ST_OK;
          res.payload_address <= 14'({pos, 4'd8});
          res.block_bytes     <= 15'({bs, 4'd0});
          res.padding_bytes   <= pad;
          res.splinter_bytes  <= 5'({spl_r, 4'd0});
          state               <= S_RESP;
        end
        // free: walk to the block start
        S_FW_RD: begin
          if (cur < tgt) begin
            state <= S_FW_EV;
          end else if (cur != tgt) begin
            res   <= '{status: ST_INVAL, default: '0};
            state <= S_RESP;
          end else begin
            state <= S_FH_EV;
          end
        end
        S_FW_EV: begin
          cur   <= cur + hsz;
          state <= S_FW_RD;
        end
        S_FH_EV: begin
          if (!hdr_rd.alloc || fh_end > {1'b0, endg}) begin
            res   <= '{status: ST_INVAL, default: '0};
            state <= S_RESP;
          end else begin
            s     <= hsz;
            hspl  <= hdr_rd.spl;
            hsize <= hdr_rd.size;
            state <= S_FF_EV;
          end
        end
        // footer must match header
        S_FF_EV: begin
          if (!ftr_rd.alloc || ftr_rd.spl != hspl || ftr_rd.size != hsize) begin
            res   <= '{status: ST_INVAL, default: '0};
            state <= S_RESP;
          end else begin
            start <= tgt;
            total <= s;
            state <= (tgt != '0) ? S_FL_EV : S_FR_RD;
          end
        end
        S_FL_EV: begin
          if (!ftr_rd.alloc && ftr_rd.size != '0 && ftr_rd.size <= tgt) begin
            start <= tgt - ftr_rd.size;
            total <= total + ftr_rd.size;
          end
          state <= S_FR_RD;
        end
        S_FR_RD: begin
          state <= (fr_pos < endg) ? S_FR_EV : S_FREE_WR;
        end
        S_FR_EV: begin
          if (!hdr_rd.alloc) begin
            total <= total + hsz;
          end
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          res   <= '{status: ST_OK, default: '0};
          state <= S_RESP;
        end
        S_RESP: begin
          if (ob_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_pages_max: assert property (@(posedge clk) disable iff (rst)
    pages <= PW'(MAX_PAGES))
    else $error("page count above limit");

  a_end_tracks_pages: assert property (@(posedge clk) disable iff (rst)
    endg == CW'(CW'(pages) * CW'(PAGE_G)))
    else $error("heap end out of step with page count");

  a_tag_pair: assert property (@(posedge clk) disable iff (rst)
    hdr_req.we == ftr_req.we)
    else $error("header and footer written apart");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    res_load |=> state == S_IDLE)
    else $error("result loaded without return to idle");

endmodule

`default_nettype wire
